FILE: hdl/pcxrle_pkg.sv
// Shared types and constants for the PCX run-length scanline decoder.
// Used by pcxrle_ctrl, pcxrle_dp and pcx_rle_scanline_decoder_unit.
package pcxrle_pkg;

  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 3;
  localparam int OP_W        = 2;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 64;
  localparam int ROW_W       = 12;
  localparam int COL_W       = 12;
  localparam int PLANE_W     = 2;
  localparam int PLANE_CNT_W = 3;
  localparam int BYTE_W      = 8;
  localparam int RGB_W       = 24;
  localparam int COUNT_W     = 6;

  localparam logic [OP_W-1:0] OP_PAL_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_DATA      = 2'd1;
  localparam logic [OP_W-1:0] OP_NEW_IMAGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_BYTES     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_EXPAND = 3'd4;

  localparam logic [1:0]             RUN_MARK   = 2'b11;
  localparam logic [PLANE_CNT_W-1:0] PLANE_MAX  = 3'd4;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [RGB_W-1:0]  palette_colour;
    logic [BYTE_W-1:0] palette_index;
  } in_data_t;

  typedef struct packed {
    logic [5:0]         pad;
    logic [BYTE_W-1:0]  blue;
    logic [BYTE_W-1:0]  green;
    logic [BYTE_W-1:0]  red;
    logic [BYTE_W-1:0]  pixel_value;
    logic [PLANE_W-1:0] plane;
    logic [COL_W-1:0]   column;
    logic [ROW_W-1:0]   row;
  } out_data_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic flush;
  } pcxrle_cmd_t;

  typedef struct packed {
    logic starts_run;
    logic step_ok;
    logic run_end;
    logic flush_ok;
  } pcxrle_sts_t;

endpackage

FILE: hdl/pcxrle_ctrl.sv
// Sequencer of the PCX run-length decoder: accept, palette lookup, byte run, flush.
// Depends on pcxrle_pkg; drives pcxrle_dp through command and status structs.
module pcxrle_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_valid_i,
  output logic                     s_ready_o,
  input  pcxrle_pkg::pcxrle_sts_t  sts_i,
  output pcxrle_pkg::pcxrle_cmd_t  cmd_o
);
  import pcxrle_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOOKUP = 4'b0010,
    ST_RUN    = 4'b0100,
    ST_FLUSH  = 4'b1000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.starts_run) state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (sts_i.step_ok) begin
          cmd_o.step = 1'b1;
          if (sts_i.run_end) state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd_o.flush = 1'b1;
        if (sts_i.flush_ok) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/pcxrle_dp.sv
// Datapath of the PCX run-length decoder: registers, run state, position counters,
// palette memory, hold stage and output register. Depends on pcxrle_pkg.
module pcxrle_dp #(
  parameter int MAX_DIMENSION = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pcxrle_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pcxrle_pkg::CFG_W-1:0]         cfg_data_i,
  input  pcxrle_pkg::in_data_t                 s_tdata_i,
  input  logic [pcxrle_pkg::OP_W-1:0]          s_tuser_i,
  input  pcxrle_pkg::pcxrle_cmd_t              cmd_i,
  output pcxrle_pkg::pcxrle_sts_t              sts_o,
  output logic                                 m_tvalid_o,
  input  logic                                 m_tready_i,
  output logic [pcxrle_pkg::OUT_DATA_W-1:0]    m_tdata_o,
  output logic                                 m_tlast_o,
  output logic                                 m_tuser_o
);
  import pcxrle_pkg::*;

  localparam int DIM_W  = $clog2(MAX_DIMENSION);
  localparam int LIM_W  = $clog2(MAX_DIMENSION + 1);
  localparam int CMP_W  = (DIM_W + 1 > CFG_W) ? DIM_W + 1 : CFG_W;
  localparam int PAL_AW = $clog2(PALETTE_DEPTH);
  localparam int IDX_W  = BYTE_W + 1;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   column;
    logic [PLANE_W-1:0] plane;
    logic [BYTE_W-1:0]  value;
    logic [RGB_W-1:0]   rgb;
    logic               done;
  } result_t;

  function automatic logic [LIM_W-1:0] clamp_dim(logic [CFG_W-1:0] v);
    logic [LIM_W-1:0] r;
    if (v == '0) begin
      r = LIM_W'(1);
    end else if (CMP_W'(v) > CMP_W'(MAX_DIMENSION)) begin
      r = LIM_W'(MAX_DIMENSION);
    end else begin
      r = LIM_W'(v);
    end
    return r;
  endfunction

  function automatic logic [PLANE_CNT_W-1:0] clamp_planes(logic [PLANE_CNT_W-1:0] v);
    logic [PLANE_CNT_W-1:0] r;
    if (v == '0) begin
      r = PLANE_CNT_W'(1);
    end else if (v > PLANE_MAX) begin
      r = PLANE_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [LIM_W-1:0]       lb_q, ht_q;
  logic [CFG_W-1:0]       iw_q;
  logic [PLANE_CNT_W-1:0] pc_q;
  logic                   expand_q;

  logic [COUNT_W-1:0] rem_q, rem_d;
  logic [BYTE_W-1:0]  val_q, val_d;
  logic               await_q, await_d;
  logic [DIM_W-1:0]   row_q, row_d;
  logic [DIM_W-1:0]   pos_q, pos_d;
  logic [PLANE_W-1:0] plane_q, plane_d;
  logic               fin_q, fin_d;

  result_t hold_q, hold_d;
  logic    hold_vld_q, hold_vld_d;
  result_t out_q, out_d;
  logic    out_vld_q, out_vld_d;
  logic    out_last_q, out_last_d;

  logic [RGB_W-1:0] pal_mem [PALETTE_DEPTH];
  logic [RGB_W-1:0] rd_q;
  logic             pal_we;

  logic                   is_run_byte, data_go;
  logic [DIM_W:0]         pos_inc, row_inc;
  logic [PLANE_CNT_W-1:0] plane_inc;
  logic [CMP_W-1:0]       vis;
  logic                   visible, wrap_pos, wrap_plane, wrap_row, done;
  logic                   pal_ok, out_free;
  logic [RGB_W-1:0]       rgb;
  result_t                cur;
  out_data_t              pkt;

  // Configuration registers; line bytes, height and plane count are clamped on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lb_q     <= LIM_W'(1);
      iw_q     <= CFG_W'(1);
      ht_q     <= LIM_W'(1);
      pc_q     <= PLANE_CNT_W'(1);
      expand_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_LINE_BYTES:     lb_q     <= clamp_dim(cfg_data_i);
        REG_IMAGE_WIDTH:    iw_q     <= cfg_data_i;
        REG_IMAGE_HEIGHT:   ht_q     <= clamp_dim(cfg_data_i);
        REG_PLANE_COUNT:    pc_q     <= clamp_planes(cfg_data_i[PLANE_CNT_W-1:0]);
        REG_PALETTE_EXPAND: expand_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    is_run_byte = (s_tdata_i.data_byte[BYTE_W-1:BYTE_W-2] == RUN_MARK);
    data_go     = (s_tuser_i == OP_DATA) && !fin_q;

    pos_inc   = (DIM_W + 1)'(pos_q) + 1'b1;
    row_inc   = (DIM_W + 1)'(row_q) + 1'b1;
    plane_inc = PLANE_CNT_W'(plane_q) + 1'b1;
    vis       = (CMP_W'(iw_q) < CMP_W'(lb_q)) ? CMP_W'(iw_q) : CMP_W'(lb_q);

    visible    = CMP_W'(pos_q) < CMP_W'(iw_q);
    wrap_pos   = CMP_W'(pos_inc) >= CMP_W'(lb_q);
    wrap_plane = wrap_pos && (plane_inc >= pc_q);
    wrap_row   = wrap_plane && (CMP_W'(row_inc) >= CMP_W'(ht_q));
    done       = visible && (CMP_W'(pos_inc) == vis) && (plane_inc == pc_q) &&
                 (CMP_W'(row_inc) == CMP_W'(ht_q));

    pal_ok   = IDX_W'(val_q) < IDX_W'(PALETTE_DEPTH);
    rgb      = (expand_q && pal_ok) ? rd_q : '0;
    out_free = !out_vld_q || m_tready_i;

    cur.row    = ROW_W'(row_q);
    cur.column = COL_W'(pos_q);
    cur.plane  = plane_q;
    cur.value  = val_q;
    cur.rgb    = rgb;
    cur.done   = done;

    sts_o.starts_run = data_go && (await_q || !is_run_byte);
    sts_o.step_ok    = !(visible && hold_vld_q && !out_free);
    sts_o.run_end    = wrap_plane || (rem_q == COUNT_W'(1));
    sts_o.flush_ok   = !hold_vld_q || out_free;
  end

  always_comb begin
    rem_d      = rem_q;
    val_d      = val_q;
    await_d    = await_q;
    row_d      = row_q;
    pos_d      = pos_q;
    plane_d    = plane_q;
    fin_d      = fin_q;
    hold_d     = hold_q;
    hold_vld_d = hold_vld_q;
    out_d      = out_q;
    out_last_d = out_last_q;
    out_vld_d  = out_vld_q && !m_tready_i;
    pal_we     = 1'b0;

    if (cmd_i.accept) begin
      case (s_tuser_i)
        OP_PAL_WRITE: begin
          pal_we = IDX_W'(s_tdata_i.palette_index) < IDX_W'(PALETTE_DEPTH);
        end
        OP_NEW_IMAGE: begin
          rem_d   = '0;
          val_d   = '0;
          await_d = 1'b0;
          row_d   = '0;
          pos_d   = '0;
          plane_d = '0;
          fin_d   = 1'b0;
        end
        OP_DATA: begin
          if (!fin_q) begin
            if (await_q) begin
              await_d = 1'b0;
              val_d   = s_tdata_i.data_byte;
            end else if (is_run_byte) begin
              rem_d   = s_tdata_i.data_byte[COUNT_W-1:0];
              await_d = (s_tdata_i.data_byte[COUNT_W-1:0] != '0);
            end else begin
              val_d = s_tdata_i.data_byte;
              rem_d = COUNT_W'(1);
            end
          end
        end
        default: ;
      endcase
    end

    if (cmd_i.step) begin
      rem_d = sts_o.run_end ? '0 : rem_q - 1'b1;
      if (wrap_pos) begin
        pos_d = '0;
        if (wrap_plane) begin
          plane_d = '0;
          if (wrap_row) begin
            row_d = '0;
            fin_d = 1'b1;
          end else begin
            row_d = row_inc[DIM_W-1:0];
          end
        end else begin
          plane_d = plane_inc[PLANE_W-1:0];
        end
      end else begin
        pos_d = pos_inc[DIM_W-1:0];
      end
      if (visible) begin
        hold_d     = cur;
        hold_vld_d = 1'b1;
        if (hold_vld_q) begin
          out_d      = hold_q;
          out_last_d = 1'b0;
          out_vld_d  = 1'b1;
        end
      end
    end

    if (cmd_i.flush && hold_vld_q && out_free) begin
      out_d      = hold_q;
      out_last_d = 1'b1;
      out_vld_d  = 1'b1;
      hold_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q      <= '0;
      val_q      <= '0;
      await_q    <= 1'b0;
      row_q      <= '0;
      pos_q      <= '0;
      plane_q    <= '0;
      fin_q      <= 1'b0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      rem_q      <= rem_d;
      val_q      <= val_d;
      await_q    <= await_d;
      row_q      <= row_d;
      pos_q      <= pos_d;
      plane_q    <= plane_d;
      fin_q      <= fin_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q     <= hold_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem[s_tdata_i.palette_index[PAL_AW-1:0]] <= s_tdata_i.palette_colour;
    end
    rd_q <= pal_mem[val_q[PAL_AW-1:0]];
  end

  always_comb begin
    pkt.pad         = '0;
    pkt.blue        = out_q.rgb[7:0];
    pkt.green       = out_q.rgb[15:8];
    pkt.red         = out_q.rgb[23:16];
    pkt.pixel_value = out_q.value;
    pkt.plane       = out_q.plane;
    pkt.column      = out_q.column;
    pkt.row         = out_q.row;
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = pkt;
  assign m_tlast_o  = out_last_q;
  assign m_tuser_o  = out_q.done;

endmodule

FILE: hdl/pcx_rle_scanline_decoder_unit.sv
// PCX run-length scanline decoder, top level. Palette writes, run markers, new-image
// commands and ignored bytes are handled in the idle state. A literal or a run value
// byte goes through the registered palette read, then places one decoded byte of its
// run (up to 63) per cycle by the position counters unless the output stalls, and then
// releases the final result with tlast set. A stalled output port holds the run.
// Depends on pcxrle_pkg, pcxrle_ctrl and pcxrle_dp.
module pcx_rle_scanline_decoder_unit #(
  parameter int MAX_DIMENSION = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pcxrle_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pcxrle_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // palette_index [7:0], palette_colour [31:8], data_byte [39:32]
  input  logic [pcxrle_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // opcode [1:0]
  input  logic [pcxrle_pkg::OP_W-1:0]          s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // row [11:0], column [23:12], plane [25:24], pixel_value [33:26],
  // red [41:34], green [49:42], blue [57:50], zero [63:58]
  output logic [pcxrle_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  output logic                                 m_axis_tlast_o,
  // image_done [0]
  output logic                                 m_axis_tuser_o
);
  import pcxrle_pkg::*;

  pcxrle_cmd_t cmd;
  pcxrle_sts_t sts;

  pcxrle_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  pcxrle_dp #(
    .MAX_DIMENSION (MAX_DIMENSION),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tuser_i   (s_axis_tuser_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_o   (m_axis_tdata_o),
    .m_tlast_o   (m_axis_tlast_o),
    .m_tuser_o   (m_axis_tuser_o)
  );

endmodule
